// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ACD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ACD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ACD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/acd_pkg.sv =====
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types, constants and AES inverse-cipher functions.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam int MAX_ROUNDS_DEF = 14;
  localparam int WIDX_W         = 6;   // word index into the key schedule
  localparam int ROW_W          = 4;   // round index
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd4;

  localparam logic ACT_LOAD_IV = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef logic [7:0] box_t [256];

  typedef struct packed {
    logic              exp_step;
    logic              exp_first;
    logic [WIDX_W-1:0] exp_idx;
    logic [2:0]        exp_j;      // word index modulo Nk
    logic              blk_load;
    logic              iv_load;
    logic [ROW_W-1:0]  rd_addr;
    logic              add_first;
    logic              round;
    logic              fin;
  } acd_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] nr;
    logic [3:0]       nk;
  } acd_sts_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xt(x);
    end
    return r;
  endfunction

  function automatic box_t gen_fwd();
    box_t       t;
    logic [7:0] base;
    logic [7:0] acc;
    int         e;
    for (int x = 0; x < 256; x++) begin
      base = 8'(x);
      acc  = 8'h01;
      e    = 254;
      while (e != 0) begin
        if (e % 2 == 1) acc = gmul(acc, base);
        base = gmul(base, base);
        e = e / 2;
      end
      t[x] = acc ^ {acc[6:0], acc[7]} ^ {acc[5:0], acc[7:6]} ^
             {acc[4:0], acc[7:5]} ^ {acc[3:0], acc[7:4]} ^ 8'h63;
    end
    return t;
  endfunction

  function automatic box_t gen_inv();
    box_t f;
    box_t t;
    f = gen_fwd();
    for (int x = 0; x < 256; x++) t[f[x]] = 8'(x);
    return t;
  endfunction

  localparam box_t FWD_BOX = gen_fwd();
  localparam box_t INV_BOX = gen_inv();

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
  endfunction

  // byte k of the state sits at bits [127-8k -: 8]
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = INV_BOX[s[127-8*(4*((c-r+4)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
      t[119-32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
      t[111-32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
      t[103-32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
    end
    return t;
  endfunction

endpackage

// ===== src/acd_if.sv =====
// ----------------------------------------------------------------------------
// acd_in_if / acd_out_if
// Valid/ready channels for ciphertext items and plaintext results.
// ----------------------------------------------------------------------------
interface acd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, action, block_high, block_low, input ready);
  modport sink   (input valid, action, block_high, block_low, output ready);
endinterface

interface acd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink   (input valid, plain_high, plain_low, output ready);
endinterface

// ===== src/acd_dp.sv =====
// ----------------------------------------------------------------------------
// acd_dp
// Key registers, key schedule, round-key memory and inverse round datapath.
// ----------------------------------------------------------------------------
module acd_dp #(
  parameter int MAX_ROUNDS = acd_pkg::MAX_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [acd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [63:0]                   in_block_high,
  input  logic [63:0]                   in_block_low,
  input  acd_pkg::acd_cmd_t             cmd,
  output acd_pkg::acd_sts_t             sts,
  output logic [63:0]                   plain_high,
  output logic [63:0]                   plain_low
);
  import acd_pkg::*;

  localparam int ROWS = MAX_ROUNDS + 1;

  logic [63:0]  key_w_r [4];
  logic [1:0]   key_size_r;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] blk_r;
  logic [127:0] st_r, st_nxt;
  logic [127:0] out_r;
  logic [127:0] rk_r;
  logic [127:0] mem [ROWS];
  logic [31:0]  win_r [8];
  logic [31:0]  rowbuf_r [3];
  logic [7:0]   rcon_r, rcon_nxt;
  logic [1:0]   ks;
  logic [ROW_W-1:0] nr;
  logic [31:0]  prev_w, old_w, kw, t_w;

  always_comb begin
    ks = (key_size_r == 2'd3) ? 2'd2 : key_size_r;
    nr = ROW_W'(10) + {1'b0, ks, 1'b0};
    if (nr > ROW_W'(MAX_ROUNDS)) nr = ROW_W'(MAX_ROUNDS);
    sts.nr = nr;
    sts.nk = 4'd4 + {1'b0, ks, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) key_w_r[k] <= '0;
      key_size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:     key_w_r[0] <= cfg_data;
        REG_KEY1:     key_w_r[1] <= cfg_data;
        REG_KEY2:     key_w_r[2] <= cfg_data;
        REG_KEY3:     key_w_r[3] <= cfg_data;
        REG_KEY_SIZE: key_size_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // key schedule: one word per step, window holds the last eight words
  always_comb begin
    prev_w   = win_r[0];
    case (sts.nk)
      4'd4:    old_w = win_r[3];
      4'd6:    old_w = win_r[5];
      default: old_w = win_r[7];
    endcase
    kw       = key_w_r[cmd.exp_idx[2:1]][cmd.exp_idx[0] ? 31 : 63 -: 32];
    rcon_nxt = cmd.exp_first ? 8'h01 : rcon_r;
    if (cmd.exp_idx < WIDX_W'(sts.nk)) begin
      t_w = kw;
    end else if (cmd.exp_j == 3'd0) begin
      t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_r, 24'h0} ^ old_w;
      rcon_nxt = xt(rcon_r);
    end else if (sts.nk == 4'd8 && cmd.exp_j == 3'd4) begin
      t_w = sub_word(prev_w) ^ old_w;
    end else begin
      t_w = prev_w ^ old_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step) begin
      rcon_r   <= rcon_nxt;
      win_r[0] <= t_w;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
      if (cmd.exp_idx[1:0] != 2'd3) rowbuf_r[cmd.exp_idx[1:0]] <= t_w;
      else mem[cmd.exp_idx[WIDX_W-1:2]] <= {rowbuf_r[0], rowbuf_r[1], rowbuf_r[2], t_w};
    end
    rk_r <= mem[cmd.rd_addr];
  end

  always_comb begin
    st_nxt    = st_r;
    chain_nxt = chain_r;
    if (cmd.add_first) st_nxt = blk_r ^ rk_r;
    if (cmd.round)     st_nxt = inv_mix(inv_shift_sub(st_r) ^ rk_r);
    if (cmd.iv_load)   chain_nxt = {in_block_high, in_block_low};
    if (cmd.fin)       chain_nxt = blk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) chain_r <= '0;
    else chain_r <= chain_nxt;
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (cmd.blk_load) blk_r <= {in_block_high, in_block_low};
    if (cmd.fin)      out_r <= inv_shift_sub(st_r) ^ rk_r ^ chain_r;
  end

  assign plain_high = out_r[127:64];
  assign plain_low  = out_r[63:0];

endmodule

// ===== src/acd_ctrl.sv =====
// ----------------------------------------------------------------------------
// acd_ctrl
// Sequencer for key expansion and the inverse-cipher rounds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [acd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          in_valid,
  input  logic                          in_action,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  acd_pkg::acd_sts_t             sts,
  output acd_pkg::acd_cmd_t             cmd
);
  import acd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_ADDK   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_FINAL  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WIDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]        j_r, j_nxt;
  logic [ROW_W-1:0]  rnd_r, rnd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              cfg_hit;

  assign cfg_hit  = cfg_we && (cfg_index <= REG_KEY_SIZE);
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    cmd.exp_idx = idx_r;
    cmd.exp_j   = j_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_DECRYPT) begin
            cmd.blk_load = 1'b1;
            cmd.rd_addr  = sts.nr;
            state_nxt    = ST_ADDK;
          end else begin
            cmd.iv_load = 1'b1;
          end
        end
      end
      ST_EXPAND: begin
        cmd.exp_step  = 1'b1;
        cmd.exp_first = (idx_r == '0);
        idx_nxt = idx_r + 1'b1;
        j_nxt   = ({1'b0, j_r} == sts.nk - 4'd1) ? 3'd0 : j_r + 3'd1;
        if (idx_r == {sts.nr, 2'b11}) state_nxt = ST_IDLE;
      end
      ST_ADDK: begin
        cmd.add_first = 1'b1;
        cmd.rd_addr   = sts.nr - 1'b1;
        rnd_nxt       = sts.nr - 1'b1;
        state_nxt     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round   = 1'b1;
        cmd.rd_addr = rnd_r - 1'b1;
        rnd_nxt     = rnd_r - 1'b1;
        if (rnd_r == ROW_W'(1)) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a write to a key or key-size register restarts the key schedule
    if (cfg_hit) begin
      state_nxt = ST_EXPAND;
      idx_nxt   = '0;
      j_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      j_r         <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ACD_NEVER(a_rdy_busy, clk, rst_n, in_ready && (state_r != ST_IDLE), "ready while busy")
  `ACD_ASSERT(a_cfg_exp, clk, rst_n, cfg_hit |=> (state_r == ST_EXPAND), "no key expansion")
  `ACD_NEVER(a_rnd_zero, clk, rst_n, (state_r == ST_ROUND) && (rnd_r == '0), "round zero")
  `ACD_ASSERT(a_fin_out, clk, rst_n, cmd.fin |=> out_valid_r, "result lost")

endmodule

// ===== src/aes_cbc_decrypt.sv =====
// ----------------------------------------------------------------------------
// aes_cbc_decrypt
// AES-128/192/256 CBC decryption, one inverse round per cycle.
// ----------------------------------------------------------------------------
// Usage: write key_word_0..3 and key_size on the cfg port (index 0..4). Each
// write re-expands the key schedule into the round-key memory, one 32-bit word
// per cycle; in_ch.ready is low meanwhile.
// in_ch beat with action 0 loads the chaining value and yields nothing.
// in_ch beat with action 1 decrypts one block: initial key addition, then one
// inverse round per cycle, then the final round with the chaining XOR, after
// which out_ch.valid rises together with in_ch.ready. One item is in flight
// at a time; the next is taken as soon as the sequencer is idle, even while
// the result still waits in the output register.
// A stalled out_ch holds the result; a further block finishes its rounds and
// waits in its last round until the output register frees.
// Reset clears the key, key size, chaining value and control; the round-key
// memory is undefined until a configuration write.
// ----------------------------------------------------------------------------
module aes_cbc_decrypt #(
  parameter int MAX_ROUNDS = acd_pkg::MAX_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  acd_in_if.sink                         in_ch,
  acd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [acd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import acd_pkg::*;

  acd_cmd_t cmd;
  acd_sts_t sts;

  acd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  acd_dp #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_block_high (in_ch.block_high),
    .in_block_low  (in_ch.block_low),
    .cmd           (cmd),
    .sts           (sts),
    .plain_high    (out_ch.plain_high),
    .plain_low     (out_ch.plain_low)
  );

endmodule

// ===== dv/acd_plain_checker.sv =====
// ----------------------------------------------------------------------------
// acd_plain_checker
// Watches the cipher, plaintext and configuration ports of aes_cbc_decrypt,
// keeps its own key schedule and chaining value, predicts the plaintext of
// every decrypt beat and compares it with the beats leaving the block.
// ----------------------------------------------------------------------------
module acd_plain_checker
  import acd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  acd_in_if                     in_ch,
  acd_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  logic [7:0]   sbox [256];
  logic [7:0]   ibox [256];
  logic [63:0]  key [4];
  logic [1:0]   ksize;
  logic [127:0] chain;
  logic [31:0]  rk [60];
  logic [127:0] plain_q [$];

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  // S-box from exp/log tables over generator 3, then the affine map
  initial begin
    logic [7:0] ex [256];
    int         lg [256];
    logic [7:0] e, v;
    errors = 0;
    pending = 0;
    e = 8'h01;
    for (int i = 0; i < 255; i++) begin
      ex[i] = e;
      lg[e] = i;
      e = e ^ dbl(e);
    end
    for (int x = 0; x < 256; x++) begin
      v = (x == 0) ? 8'h00 : ex[(255 - lg[x]) % 255];
      v = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]} ^ 8'h63;
      sbox[x] = v;
      ibox[v] = 8'(x);
    end
  end

  function automatic int nrounds();
    return 10 + 2 * ((ksize == 2'd3) ? 2 : int'(ksize));
  endfunction

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {sbox[w[31:24]], sbox[w[23:16]], sbox[w[15:8]], sbox[w[7:0]]};
  endfunction

  task automatic expand_schedule();
    int          nk, total;
    logic [31:0] t;
    logic [7:0]  rc;
    nk = (ksize == 2'd3) ? 8 : 4 + 2 * int'(ksize);
    total = 4 * (nrounds() + 1);
    rc = 8'h01;
    for (int i = 0; i < total; i++) begin
      if (i < nk) begin
        t = (i % 2) ? key[i / 2][31:0] : key[i / 2][63:32];
      end else begin
        t = rk[i - 1];
        if (i % nk == 0) begin
          t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = dbl(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = subw(t);
        end
        t ^= rk[i - nk];
      end
      rk[i] = t;
    end
  endtask

  function automatic logic [127:0] inv_cipher(input logic [127:0] ct);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] res;
    int           nr;
    nr = nrounds();
    for (int k = 0; k < 16; k++) s[k] = ct[127 - 8 * k -: 8];
    for (int rnd = nr; rnd >= 0; rnd--) begin
      if (rnd != nr) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4 * c + r] = ibox[s[4 * ((c - r + 4) % 4) + r]];
        s = t;
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4 * c + r] ^= rk[4 * rnd + c][31 - 8 * r -: 8];
      if (rnd != nr && rnd != 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
          s[4 * c]     = fmul(a0, 14) ^ fmul(a1, 11) ^ fmul(a2, 13) ^ fmul(a3, 9);
          s[4 * c + 1] = fmul(a0, 9) ^ fmul(a1, 14) ^ fmul(a2, 11) ^ fmul(a3, 13);
          s[4 * c + 2] = fmul(a0, 13) ^ fmul(a1, 9) ^ fmul(a2, 14) ^ fmul(a3, 11);
          s[4 * c + 3] = fmul(a0, 11) ^ fmul(a1, 13) ^ fmul(a2, 9) ^ fmul(a3, 14);
        end
      end
    end
    for (int k = 0; k < 16; k++) res[127 - 8 * k -: 8] = s[k];
    return res;
  endfunction

  // sampled mid-cycle: stimulus and block outputs only move on the rising edge
  always @(negedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      foreach (key[i]) key[i] = '0;
      ksize = '0;
      chain = '0;
      plain_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (plain_q.size() == 0) begin
          $error("unexpected plaintext beat %h %h", out_ch.plain_high, out_ch.plain_low);
          errors++;
        end else begin
          want = plain_q.pop_front();
          if (out_ch.plain_high !== want[127:64]) begin
            $error("plain_high: expected %h, actual %h", want[127:64], out_ch.plain_high);
            errors++;
          end
          if (out_ch.plain_low !== want[63:0]) begin
            $error("plain_low: expected %h, actual %h", want[63:0], out_ch.plain_low);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index < REG_KEY_SIZE) begin
          key[cfg_index] = cfg_data;
          expand_schedule();
        end else if (cfg_index == REG_KEY_SIZE) begin
          ksize = cfg_data[1:0];
          expand_schedule();
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_DECRYPT)
          plain_q.push_back(inv_cipher({in_ch.block_high, in_ch.block_low}) ^ chain);
        chain = {in_ch.block_high, in_ch.block_low};
      end
    end
    pending = plain_q.size();
  end

endmodule

// ===== dv/tb_aes_cbc_decrypt.sv =====
// ----------------------------------------------------------------------------
// tb_aes_cbc_decrypt
// Drives aes_cbc_decrypt through several key sizes and keys with directed and
// random IV loads and decrypt beats under random stalls on both channels;
// acd_plain_checker predicts and checks every plaintext beat.
// ----------------------------------------------------------------------------
module tb_aes_cbc_decrypt;
  import acd_pkg::*;

  localparam int LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    cycles;
  int                    stall_left;
  bit                    calm;

  acd_in_if  in_ch ();
  acd_out_if out_ch ();

  aes_cbc_decrypt uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  acd_plain_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called right after a rising edge; returns at the edge that accepts the beat
  task automatic send_beat(input logic act, input logic [63:0] hi, input logic [63:0] lo);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.block_high <= hi;
    in_ch.block_low  <= lo;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  // sender pauses until every plaintext is back and the core is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    // key expansion holds off the input channel
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task automatic random_beats(input int n);
    for (int i = 0; i < n; i++)
      send_beat(($urandom_range(0, 4) == 0) ? ACT_LOAD_IV : ACT_DECRYPT, rnd64(), rnd64());
  endtask

  initial begin
    logic [63:0] kfill;
    logic [1:0]  ksz;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    stall_left = 0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD_IV;
    in_ch.block_high = '0;
    in_ch.block_low = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 7; p++) begin
      calm = (p == 6);
      drain();
      case (p)
        0: begin kfill = '0; ksz = 2'd0; end
        1: begin kfill = '1; ksz = 2'd2; end
        2: begin kfill = 'x; ksz = 2'd1; end
        3: begin kfill = 'x; ksz = 2'd3; end   // size 3 runs as 256 bit
        4: begin kfill = 'x; ksz = 2'd0; end
        5: begin kfill = 'x; ksz = 2'd2; end
        default: begin kfill = '1; ksz = 2'd1; end
      endcase
      for (int w = 0; w < 4; w++)
        write_reg(CFG_IDX_W'(w), (p >= 2 && p <= 5) ? rnd64() : kfill);
      write_reg(REG_KEY_SIZE, {62'h0, ksz});
      if (p == 2) begin
        // out-of-range indexes must leave the schedule alone
        write_reg(3'd5, '1);
        write_reg(3'd7, {$urandom, $urandom});
      end
      if (p == 0) begin
        send_beat(ACT_DECRYPT, '0, '0);
        send_beat(ACT_DECRYPT, '1, '1);
        send_beat(ACT_LOAD_IV, '1, '1);
        send_beat(ACT_DECRYPT, '0, '0);
        send_beat(ACT_DECRYPT, 64'h8000_0000_0000_0000, 64'h1);
        send_beat(ACT_LOAD_IV, '0, '0);
        send_beat(ACT_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_beat(ACT_LOAD_IV, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_beat(ACT_DECRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_beat(ACT_LOAD_IV, '1, '0);
        send_beat(ACT_LOAD_IV, '0, '1);
        send_beat(ACT_DECRYPT, '1, '0);
        send_beat(ACT_DECRYPT, '0, '1);
        send_beat(ACT_DECRYPT, {$urandom, $urandom}, {$urandom, $urandom});
        send_beat(ACT_DECRYPT, {$urandom, $urandom}, {$urandom, $urandom});
      end
      random_beats(55);
      if (p == 3) drain();
      random_beats(55);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
